@@ design/drc_pkg.sv @@
// Package: shared types, constants and helpers of the draw range coalescer.
`timescale 1ns / 1ps

package drc_pkg;

  localparam int unsigned MAT_W   = 16;
  localparam int unsigned MTX_W   = 24;
  localparam int unsigned OFS_W   = 32;
  localparam int unsigned CNT_W   = 30;
  localparam int unsigned RNG_W   = 16;
  localparam int unsigned SHIFT_W = 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [RNG_W-1:0] RANGES_MAX = {RNG_W{1'b1}};

  // Register index, taken from paddr[2].
  localparam logic REG_COMBINE = 1'b0;
  localparam logic REG_SHIFT   = 1'b1;

  localparam logic             COMBINE_RESET = 1'b1;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 2'd2;

  typedef struct packed {
    logic [MAT_W-1:0] material_id;
    logic [MTX_W-1:0] matrix_id;
    logic [OFS_W-1:0] byte_offset;
    logic [CNT_W-1:0] index_count;
    logic             list_end;
  } drc_in_t;

  typedef struct packed {
    logic [OFS_W-1:0] out_offset;
    logic [CNT_W-1:0] out_count;
    logic             group_close;
    logic [MAT_W-1:0] group_material;
    logic [MTX_W-1:0] group_matrix;
    logic [RNG_W-1:0] group_ranges;
    logic             final_result;
  } drc_out_t;

  // Up to two results caused by one item, in delivery order.
  typedef struct packed {
    logic     v0;
    drc_out_t r0;
    logic     v1;
    drc_out_t r1;
  } drc_pair_t;

  typedef struct packed {
    logic               combine_enable;
    logic [SHIFT_W-1:0] index_size_shift;
  } drc_cfg_t;

  function automatic logic [RNG_W-1:0] sat_inc(input logic [RNG_W-1:0] v);
    sat_inc = (v == RANGES_MAX) ? RANGES_MAX : v + 1'b1;
  endfunction

endpackage

@@ design/drc_regs.sv @@
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module drc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drc_pkg::ADDR_W-1:0]  paddr,
  input  logic [drc_pkg::DATA_W-1:0]  pwdata,
  output logic [drc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output drc_pkg::drc_cfg_t           cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.combine_enable   <= drc_pkg::COMBINE_RESET;
      cfg.index_size_shift <= drc_pkg::SHIFT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        drc_pkg::REG_COMBINE: cfg.combine_enable <= pwdata[0];
        drc_pkg::REG_SHIFT:   cfg.index_size_shift <= pwdata[drc_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      drc_pkg::REG_COMBINE: prdata = {{(drc_pkg::DATA_W-1){1'b0}}, cfg.combine_enable};
      drc_pkg::REG_SHIFT:
        prdata = {{(drc_pkg::DATA_W-drc_pkg::SHIFT_W){1'b0}}, cfg.index_size_shift};
      default: prdata = '0;
    endcase
  end

endmodule

@@ design/drc_engine.sv @@
// Coalescing state and the single-pass step that turns one item into its results.
`timescale 1ns / 1ps

module drc_engine (
  input  logic                clk,
  input  logic                rst,
  input  drc_pkg::drc_cfg_t   cfg,
  input  drc_pkg::drc_in_t    item,
  input  logic                fire,
  output drc_pkg::drc_pair_t  pair
);

  logic                        run_open;
  logic [drc_pkg::MAT_W-1:0]   cur_material;
  logic [drc_pkg::MTX_W-1:0]   cur_matrix;
  logic [drc_pkg::OFS_W-1:0]   run_offset;
  logic [drc_pkg::CNT_W-1:0]   run_count;
  logic [drc_pkg::RNG_W-1:0]   ranges_so_far;

  logic [drc_pkg::MAT_W-1:0]   mat_mid;
  logic [drc_pkg::MTX_W-1:0]   mtx_mid;
  logic [drc_pkg::OFS_W-1:0]   ofs_mid;
  logic [drc_pkg::CNT_W-1:0]   cnt_mid;
  logic [drc_pkg::RNG_W-1:0]   rng_mid;

  logic                        run_open_next;
  logic [drc_pkg::RNG_W-1:0]   ranges_so_far_next;

  logic                        key_diff;
  logic                        merge;
  logic [drc_pkg::OFS_W+1:0]   end_ofs;
  logic [drc_pkg::CNT_W:0]     cnt_sum;
  logic [drc_pkg::CNT_W-1:0]   cnt_sat;

  always_comb begin
    key_diff = (item.material_id != cur_material) || (item.matrix_id != cur_matrix);
    // End of the open range, kept wide so that it never wraps.
    end_ofs  = {2'b00, run_offset} +
               ({4'b0000, run_count} << cfg.index_size_shift);
    merge    = run_open && !key_diff && cfg.combine_enable &&
               (end_ofs == {2'b00, item.byte_offset});
    cnt_sum  = {1'b0, run_count} + {1'b0, item.index_count};
    cnt_sat  = cnt_sum[drc_pkg::CNT_W] ? drc_pkg::COUNT_MAX : cnt_sum[drc_pkg::CNT_W-1:0];

    // First result: the open range leaves when it is not merged.
    pair.v0                = run_open && !merge;
    pair.r0.out_offset     = run_offset;
    pair.r0.out_count      = run_count;
    pair.r0.group_close    = key_diff;
    pair.r0.group_material = cur_material;
    pair.r0.group_matrix   = cur_matrix;
    pair.r0.group_ranges   = key_diff ? drc_pkg::sat_inc(ranges_so_far) : '0;
    pair.r0.final_result   = 1'b0;

    // State after the item itself, before the list end is applied.
    mat_mid = cur_material;
    mtx_mid = cur_matrix;
    ofs_mid = item.byte_offset;
    cnt_mid = item.index_count;
    rng_mid = ranges_so_far;
    if (!run_open || key_diff) begin
      mat_mid = item.material_id;
      mtx_mid = item.matrix_id;
      rng_mid = '0;
    end else if (merge) begin
      ofs_mid = run_offset;
      cnt_mid = cnt_sat;
    end else begin
      rng_mid = drc_pkg::sat_inc(ranges_so_far);
    end

    // Second result: the list end flushes whatever range is now open.
    pair.v1                = item.list_end;
    pair.r1.out_offset     = ofs_mid;
    pair.r1.out_count      = cnt_mid;
    pair.r1.group_close    = 1'b1;
    pair.r1.group_material = mat_mid;
    pair.r1.group_matrix   = mtx_mid;
    pair.r1.group_ranges   = drc_pkg::sat_inc(rng_mid);
    pair.r1.final_result   = 1'b1;

    run_open_next      = !item.list_end;
    ranges_so_far_next = item.list_end ? '0 : rng_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open      <= 1'b0;
      cur_material  <= '0;
      cur_matrix    <= '0;
      run_offset    <= '0;
      run_count     <= '0;
      ranges_so_far <= '0;
    end else if (fire) begin
      run_open      <= run_open_next;
      cur_material  <= mat_mid;
      cur_matrix    <= mtx_mid;
      run_offset    <= ofs_mid;
      run_count     <= cnt_mid;
      ranges_so_far <= ranges_so_far_next;
    end
  end

endmodule

@@ design/drc_outbuf.sv @@
// Result register pair that hands out the results of one item one beat at a time.
`timescale 1ns / 1ps

module drc_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  drc_pkg::drc_pair_t  pair,
  input  logic                fire,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output drc_pkg::drc_out_t   out_data
);

  logic              v0;
  logic              v1;
  drc_pkg::drc_out_t r0;
  drc_pkg::drc_out_t r1;
  logic              pop;
  logic              load;

  assign out_valid = v0 || v1;
  assign out_data  = v0 ? r0 : r1;
  assign pop       = out_valid && out_ready;
  // The buffer is free after this edge when nothing stays pending in it.
  // An item that causes no result may always go through.
  assign room      = !(v0 && v1) && (!out_valid || out_ready) || !(pair.v0 || pair.v1);
  assign load      = fire && (pair.v0 || pair.v1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (load) begin
      v0 <= pair.v0;
      v1 <= pair.v1;
    end else if (pop) begin
      if (v0) begin
        v0 <= 1'b0;
      end else begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0 <= pair.r0;
      r1 <= pair.r1;
    end
  end

endmodule

@@ design/draw_range_coalescer.sv @@
// Top level of the draw range coalescer: input register, engine, result buffer, registers.
`timescale 1ns / 1ps

// The block reads a sorted list of draw items on the input channel, one item
// per beat, and writes merged index ranges on the output channel, one range
// per beat. Each input beat is first captured in an input register. While it
// is held there, the engine compares it with the open range and its state key;
// once the result pair has room it updates the state and, at that clock edge,
// loads the zero, one or two ranges it causes into the result register pair.
// The first of them is offered right after that edge. Throughput is one item
// per cycle as long as each item causes at most one range and the receiver
// keeps out_ready high; an item that ends the list without merging into the
// open range causes two ranges, and the next item that causes a range then
// waits while the result pair drains one beat per cycle. When the receiver
// stalls the result pair stays full, the input register holds its item and
// in_ready drops; nothing is lost.
// The APB-style port writes combine_enable at byte 0 and index_size_shift at
// byte 4; it is meant to be written only while the block is idle.
// Synchronous reset empties the input register and result pair, closes any
// list in progress, and returns the registers to combining on and four-byte
// indices.

module draw_range_coalescer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  drc_pkg::drc_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output drc_pkg::drc_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drc_pkg::ADDR_W-1:0]  paddr,
  input  logic [drc_pkg::DATA_W-1:0]  pwdata,
  output logic [drc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  drc_pkg::drc_cfg_t  cfg;
  drc_pkg::drc_pair_t pair;
  drc_pkg::drc_in_t   item;
  logic               item_valid;
  logic               room;
  logic               fire;

  drc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held item is processed once the result pair can take what it causes.
  assign fire     = item_valid && room;
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  drc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .fire (fire),
    .pair (pair)
  );

  drc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .fire      (fire),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A held item that is not processed must still be held in the next cycle.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !fire) |=> item_valid)
    else $error("held input item dropped without being processed");

  // The last result of a list always closes its group.
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.final_result) |-> out_data.group_close)
    else $error("final result does not close its group");

  // A closing range reports at least itself; an open one reports zero.
  a_close_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.group_close ? (out_data.group_ranges != '0)
                                        : (out_data.group_ranges == '0)))
    else $error("group range count inconsistent with group_close");

  // Results are never loaded over a result that is still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (fire && (pair.v0 || pair.v1) && out_valid) |-> out_ready)
    else $error("result pair overwritten while a beat is pending");

endmodule
